@@ rtl/core/htw_pkg.sv @@
// Package for the hashed timer wheel: request and result types, command kinds.
// No dependencies; every file of the block imports it.
package htw_pkg;

	localparam logic [2:0] KIND_TICK    = 3'd0;
	localparam logic [2:0] KIND_ADD     = 3'd1;
	localparam logic [2:0] KIND_MODIFY  = 3'd2;
	localparam logic [2:0] KIND_DELETE  = 3'd3;
	localparam logic [2:0] KIND_SUSPEND = 3'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [4:0]  timer_id;
		logic [31:0] interval;
		logic        repeat_req;
	} req_t;

	typedef struct packed {
		logic       fired;
		logic [4:0] expired_timer;
		logic       last;
	} res_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_cmd_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quotient;
	} div_stat_t;

endpackage

@@ rtl/core/hashed_timer_wheel_unit.sv @@
// Top level of the hashed timer wheel: command sequencer, tick scan, result register.
// Depends on htw_pkg, htw_ram (timer entry store) and htw_div (shared divider).
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req   (req_t)
//  res      out        res_valid/res_stall  res   (res_t)
//  cfg      in         cfg_we               cfg_wdata (slot interval)
//
// A delete, suspend or ignored request completes in the cycle that accepts it. An add or
// modify goes through the accepting cycle with the entry read, a divider start, the run of
// the shared divider (interval by slot interval), then a step splitting the tick
// count into rotation and slot by a reciprocal multiply and a write-back step.
// A tick goes through the accepting cycle, a scan step per timer entry plus a check step
// for each entry that is enabled, a divider run, split and write-back for each repeating
// timer that expires, and then the end-of-scan check and the closing step.
// Reset clears the wheel position and the present/enabled bits at once; no clearing pass.
// A stall on res holds the scan only when a second expiry is found while the result
// register is still full, and holds the closing cycle until the result register frees.
module hashed_timer_wheel_unit import htw_pkg::*; #(
	parameter int SLOTS  = 64,
	parameter int TIMERS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	localparam int SW   = $clog2(SLOTS);
	localparam int IDXW = TIMERS > 1 ? $clog2(TIMERS) : 1;
	// entry layout: repeat | interval | slot | rotation
	localparam int EW   = 1 + 32 + SW + 32;
	localparam int ROT_LO = 0;
	localparam int SLT_LO = 32;
	localparam int IVL_LO = 32 + SW;
	localparam int REP_B  = 64 + SW;
	// ceil(2^(32+SW) / SLOTS): exact quotient by SLOTS for any 32-bit tick count
	localparam logic [32:0] RECIP =
		33'(((64'd1 << (32 + SW)) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

	typedef enum logic [7:0] {
		ST_IDLE = 8'b00000001,
		ST_CMD  = 8'b00000010,
		ST_SCAN = 8'b00000100,
		ST_CHK  = 8'b00001000,
		ST_ARM1 = 8'b00010000,
		ST_ARM2 = 8'b00100000,
		ST_ARM3 = 8'b01000000,
		ST_FIN  = 8'b10000000
	} state_t;

	state_t           state_q;
	logic [31:0]      slot_interval_q;
	logic [SW-1:0]    cur_q;
	logic [TIMERS-1:0] present_q;
	logic [TIMERS-1:0] enabled_q;
	logic [IDXW:0]    idx_q;
	logic [IDXW-1:0]  arm_addr_q;
	logic [31:0]      arm_ivl_q;
	logic             arm_rep_q;
	logic             arm_tick_q;
	logic             cmd_rep_q;
	logic [31:0]      ticks_q;
	logic [31:0]      arm_quo_q;
	logic [SW-1:0]    arm_rem_q;
	logic             pend_v_q;
	logic [4:0]       pend_id_q;
	logic             res_valid_q;
	res_t             res_q;

	logic             req_take;
	logic             id_ok;
	logic [IDXW-1:0]  req_addr;
	logic [IDXW-1:0]  scan_addr;
	logic             out_free;
	logic             out_load;
	res_t             out_data;
	logic             ram_we;
	logic [IDXW-1:0]  ram_waddr;
	logic [EW-1:0]    ram_wdata;
	logic             ram_re;
	logic [IDXW-1:0]  ram_raddr;
	logic [EW-1:0]    ram_rdata;
	div_cmd_t         div_cmd;
	div_stat_t        div_stat;
	logic [31:0]      si;
	logic [31:0]      ticks_n;
	logic [64:0]      arm_prod;
	logic [31:0]      quo_n;
	logic [SW-1:0]    rem_n;
	logic [SW:0]      slot_sum;
	logic [SW-1:0]    slot_n;
	logic [31:0]      rot_n;
	logic [SW-1:0]    e_slot;
	logic [31:0]      e_rot;
	logic [31:0]      e_ivl;
	logic             e_rep;
	logic             hit;
	logic             fire;

	htw_ram #(.WIDTH(EW), .DEPTH(TIMERS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	htw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.stat   (div_stat)
	);

	assign req_stall = state_q != ST_IDLE;
	assign req_take  = req_valid && !req_stall;
	assign id_ok     = {2'b00, req.timer_id} < 7'(TIMERS);
	assign req_addr  = IDXW'(req.timer_id);
	assign scan_addr = idx_q[IDXW-1:0];
	assign out_free  = !res_valid_q || !res_stall;
	assign si        = (slot_interval_q == 32'd0) ? 32'd1 : slot_interval_q;

	// fields of the entry read in the previous cycle
	assign e_rot  = ram_rdata[ROT_LO +: 32];
	assign e_slot = ram_rdata[SLT_LO +: SW];
	assign e_ivl  = ram_rdata[IVL_LO +: 32];
	assign e_rep  = ram_rdata[REP_B];
	assign hit    = e_slot == cur_q;
	assign fire   = hit && (e_rot == 32'd0);

	// arm arithmetic: minimum of one tick, then rotation and slot offset by SLOTS
	assign ticks_n  = (div_stat.quotient == 32'd0) ? 32'd1 : div_stat.quotient;
	assign arm_prod = {33'd0, ticks_q} * {32'd0, RECIP};
	assign quo_n    = 32'(arm_prod >> (32 + SW));
	// the remainder is below SLOTS, so its low SW bits are all of it
	assign rem_n    = ticks_q[SW-1:0] - SW'(quo_n[SW-1:0] * SW'(SLOTS));
	assign slot_sum = {1'b0, cur_q} + {1'b0, arm_rem_q};
	assign slot_n   = (slot_sum >= (SW+1)'(SLOTS)) ? SW'(slot_sum - (SW+1)'(SLOTS))
	                                                : slot_sum[SW-1:0];
	assign rot_n    = (arm_tick_q && slot_n == cur_q && arm_quo_q != 32'd0)
	                ? arm_quo_q - 32'd1 : arm_quo_q;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = scan_addr;
		ram_we    = 1'b0;
		ram_waddr = scan_addr;
		ram_wdata = ram_rdata;
		div_cmd   = '0;
		out_load  = 1'b0;
		out_data  = '0;
		unique case (state_q)
			ST_IDLE: begin
				ram_re    = req_take;
				ram_raddr = req_addr;
			end
			ST_CMD: begin
				div_cmd.start    = 1'b1;
				div_cmd.dividend = arm_ivl_q;
				div_cmd.divisor  = si;
			end
			ST_SCAN: begin
				ram_re = (idx_q != (IDXW+1)'(TIMERS)) && present_q[scan_addr]
				      && enabled_q[scan_addr];
			end
			ST_CHK: begin
				if (hit && !fire) begin
					// count the rotation down
					ram_we    = 1'b1;
					ram_wdata[ROT_LO +: 32] = e_rot - 32'd1;
				end
				if (fire && (!pend_v_q || out_free)) begin
					out_load = pend_v_q;
					out_data = '{fired: 1'b1, expired_timer: pend_id_q, last: 1'b0};
					if (e_rep) begin
						div_cmd.start    = 1'b1;
						div_cmd.dividend = e_ivl;
						div_cmd.divisor  = si;
					end
				end
			end
			ST_ARM3: begin
				ram_we    = 1'b1;
				ram_waddr = arm_addr_q;
				ram_wdata = {arm_rep_q, arm_ivl_q, slot_n, rot_n};
			end
			ST_FIN: begin
				out_load = out_free;
				out_data = pend_v_q
				         ? '{fired: 1'b1, expired_timer: pend_id_q, last: 1'b1}
				         : '{fired: 1'b0, expired_timer: 5'd0, last: 1'b1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			slot_interval_q <= 32'd1;
			cur_q           <= '0;
			present_q       <= '0;
			enabled_q       <= '0;
			idx_q           <= '0;
			pend_v_q        <= 1'b0;
			res_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				slot_interval_q <= cfg_wdata;
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						idx_q <= '0;
						priority if (req.kind == KIND_TICK) begin
							state_q <= ST_SCAN;
						end else if (!id_ok) begin
							state_q <= ST_IDLE;
						end else if (req.kind == KIND_ADD) begin
							state_q <= ST_CMD;
						end else if (req.kind == KIND_MODIFY) begin
							if (present_q[req_addr]) begin
								state_q <= ST_CMD;
							end
						end else if (req.kind == KIND_DELETE) begin
							present_q[req_addr] <= 1'b0;
							enabled_q[req_addr] <= 1'b0;
						end else if (req.kind == KIND_SUSPEND) begin
							enabled_q[req_addr] <= 1'b0;
						end else begin
							// drop unknown kinds
							state_q <= ST_IDLE;
						end
					end
				end
				ST_CMD: begin
					state_q <= ST_ARM1;
				end
				ST_SCAN: begin
					if (idx_q == (IDXW+1)'(TIMERS)) begin
						state_q <= ST_FIN;
					end else if (present_q[scan_addr] && enabled_q[scan_addr]) begin
						state_q <= ST_CHK;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_CHK: begin
					if (!fire) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SCAN;
					end else if (!pend_v_q || out_free) begin
						pend_v_q <= 1'b1;
						if (e_rep) begin
							state_q <= ST_ARM1;
						end else begin
							// drop the one-shot timer
							present_q[scan_addr] <= 1'b0;
							enabled_q[scan_addr] <= 1'b0;
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_ARM1: begin
					if (div_stat.done) begin
						state_q <= ST_ARM2;
					end
				end
				ST_ARM2: begin
					state_q <= ST_ARM3;
				end
				ST_ARM3: begin
					present_q[arm_addr_q] <= 1'b1;
					enabled_q[arm_addr_q] <= 1'b1;
					if (arm_tick_q) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
						cur_q    <= (cur_q == SW'(SLOTS - 1)) ? '0 : cur_q + 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers: arm context, pending result, result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q <= out_data;
		end
		if (state_q == ST_IDLE && req_take) begin
			arm_addr_q <= req_addr;
			arm_ivl_q  <= req.interval;
			cmd_rep_q  <= req.repeat_req;
			arm_tick_q <= 1'b0;
		end
		if (state_q == ST_CMD) begin
			// a re-add keeps the stored repeat flag
			arm_rep_q <= present_q[arm_addr_q] ? e_rep : cmd_rep_q;
		end
		if (state_q == ST_CHK && fire && (!pend_v_q || out_free)) begin
			pend_id_q  <= 5'(scan_addr);
			arm_addr_q <= scan_addr;
			arm_ivl_q  <= e_ivl;
			arm_rep_q  <= 1'b1;
			arm_tick_q <= 1'b1;
		end
		if (state_q == ST_ARM1 && div_stat.done) begin
			ticks_q <= ticks_n;
		end
		if (state_q == ST_ARM2) begin
			arm_quo_q <= quo_n;
			arm_rem_q <= rem_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// pending expiry never outlives its tick
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_v_q)
		else $error("pending expiry left over after tick");

	// divider runs only for an arm sequence
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == ST_ARM1))
		else $error("divider busy outside arm sequence");

	// an enabled timer is always present
	a_en_present: assert property (@(posedge clk) disable iff (!arst_n)
		(enabled_q & ~present_q) == '0)
		else $error("enabled timer without present bit");

	// closing a tick advances the wheel
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> (cur_q != $past(cur_q)))
		else $error("wheel did not advance on tick");

	// divide result is latched before the rotation and slot are split off
	a_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ARM1 && div_stat.done) |=> (ticks_q != 32'd0))
		else $error("zero tick count after first divide");

endmodule

@@ rtl/core/htw_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on htw_pkg only by house convention.
module htw_ram import htw_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/htw_div.sv @@
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// Depends on htw_pkg for the command and status structs.
module htw_div import htw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  div_cmd_t  cmd,
	output div_stat_t stat
);

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvsr_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] shifted;
	logic        fits;

	assign shifted = {rem_q, quo_q[31]};
	assign fits    = shifted >= {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q  <= '0;
			quo_q  <= cmd.dividend;
			dvsr_q <= cmd.divisor;
		end else if (busy_q) begin
			rem_q <= 32'(fits ? shifted - {1'b0, dvsr_q} : shifted);
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign stat.busy     = busy_q;
	assign stat.done     = done_q;
	assign stat.quotient = quo_q;

endmodule
